@@ hdl/pulse_count_flash_led_controller_macros.svh @@
// Assertion macros shared by the controller.
`ifndef PULSE_COUNT_FLASH_LED_CONTROLLER_MACROS_SVH
`define PULSE_COUNT_FLASH_LED_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pcfl_pkg.sv @@
package pcfl_pkg;

  localparam int TIMER_LEVELS_DEF = 16;
  localparam logic [3:0] BRIGHTNESS_LEVELS = 4'd15;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PULSE = 3'd4;

  localparam logic [19:0] FLASH_TIMEOUT_RST = 20'd16000;
  localparam logic [15:0] TIMEOUT_STEP_RST = 16'd1000;
  localparam logic [9:0] LATCH_RST = 10'd500;
  localparam logic [7:0] OFF_DELAY_RST = 8'd10;
  localparam logic [3:0] HALF_PULSE_RST = 4'd1;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_TORCH = 2'd1;
  localparam logic [1:0] REQ_STROBE = 2'd2;

  localparam logic [4:0] ADDR_CURRENT = 5'd17;
  localparam logic [4:0] CURRENT_BASE = 5'd16;
  localparam logic [4:0] ADDR_TIMER = 5'd18;
  localparam logic [4:0] ADDR_CONFIG = 5'd19;
  localparam logic [4:0] CONFIG_ON = 5'd3;
  localparam logic [4:0] ADDR_RATIO = 5'd20;
  localparam logic [4:0] RATIO_VALUE = 5'd1;

  localparam logic [1:0] WIDX_RATIO = 2'd0;
  localparam logic [1:0] WIDX_CURRENT = 2'd1;
  localparam logic [1:0] WIDX_CONFIG = 2'd2;

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_OFF = 3'd1;
  localparam logic [2:0] STEP_A_LOW = 3'd2;
  localparam logic [2:0] STEP_A_HIGH = 3'd3;
  localparam logic [2:0] STEP_A_LATCH = 3'd4;
  localparam logic [2:0] STEP_D_LOW = 3'd5;
  localparam logic [2:0] STEP_D_HIGH = 3'd6;
  localparam logic [2:0] STEP_D_LATCH = 3'd7;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_CNT_ZERO,
    COND_MORE,
    COND_LAST
  } cond_e;

  typedef enum logic [1:0] {
    EN_HOLD,
    EN_CLR,
    EN_SET
  } en_op_e;

  typedef enum logic [1:0] {
    PULSE_HOLD,
    PULSE_LOAD_ADDR,
    PULSE_LOAD_DATA,
    PULSE_DEC
  } pulse_op_e;

  typedef struct packed {
    cond_e      cond;
    logic [2:0] next;
    logic [2:0] jump;
    en_op_e     en_op;
    pulse_op_e  pulse_op;
    logic       finish;
  } ucode_t;

  // Control store: one word for each step of a register write.
  function automatic ucode_t ucode(input logic [2:0] step);
    ucode_t w;
    w.cond = COND_NONE;
    w.next = STEP_IDLE;
    w.jump = STEP_IDLE;
    w.en_op = EN_HOLD;
    w.pulse_op = PULSE_HOLD;
    w.finish = 1'b0;
    case (step)
      STEP_OFF: begin
        w.pulse_op = PULSE_LOAD_ADDR;
        w.cond = COND_CNT_ZERO;
        w.jump = STEP_A_LATCH;
        w.next = STEP_A_LOW;
      end
      STEP_A_LOW: begin
        w.en_op = EN_CLR;
        w.next = STEP_A_HIGH;
      end
      STEP_A_HIGH: begin
        w.en_op = EN_SET;
        w.pulse_op = PULSE_DEC;
        w.cond = COND_MORE;
        w.jump = STEP_A_LOW;
        w.next = STEP_A_LATCH;
      end
      STEP_A_LATCH: begin
        w.pulse_op = PULSE_LOAD_DATA;
        w.cond = COND_CNT_ZERO;
        w.jump = STEP_D_LATCH;
        w.next = STEP_D_LOW;
      end
      STEP_D_LOW: begin
        w.en_op = EN_CLR;
        w.next = STEP_D_HIGH;
      end
      STEP_D_HIGH: begin
        w.en_op = EN_SET;
        w.pulse_op = PULSE_DEC;
        w.cond = COND_MORE;
        w.jump = STEP_D_LOW;
        w.next = STEP_D_LATCH;
      end
      STEP_D_LATCH: begin
        w.finish = 1'b1;
        w.cond = COND_LAST;
        w.jump = STEP_IDLE;
        w.next = STEP_OFF;
      end
      default: begin
        w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hdl/pulse_count_flash_led_controller.sv @@
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  req_type_i, level_i
// out      out_valid_o / out_ready_i flen_pin_o, en_set_pin_o, busy_res_o,
//                                    movie_mode_on_o, cmd_dropped_o
// cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Each input beat gives one output beat, valid in the cycle after it is accepted.
// A strobe-on beat then holds off input while the timer code is found by repeated
// subtraction in the divider.
// A result beat that waits holds off input; a new beat enters in the cycle it is taken.
// Reset is asynchronous; there is no memory and no clearing pass.
`include "pulse_count_flash_led_controller_macros.svh"

module pulse_count_flash_led_controller #(
  parameter int TIMER_LEVELS = pcfl_pkg::TIMER_LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [3:0]                     level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           flen_pin_o,
  output logic                           en_set_pin_o,
  output logic                           busy_res_o,
  output logic                           movie_mode_on_o,
  output logic                           cmd_dropped_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcfl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcfl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcfl_pkg::*;

  localparam int CodeW = $clog2(TIMER_LEVELS + 1);
  localparam int PulseW = (CodeW > 5) ? CodeW : 5;
  localparam logic [CodeW-1:0] TlCode = CodeW'(TIMER_LEVELS);
  localparam logic [CodeW:0] TlPlusOne = (CodeW + 1)'(TIMER_LEVELS + 1);

  logic [19:0] flash_timeout_q;
  logic [15:0] timeout_step_q;
  logic [9:0]  latch_q;
  logic [7:0]  off_delay_q;
  logic [3:0]  half_pulse_q;

  logic              movie_q, movie_d;
  logic              flen_q, flen_d;
  logic              en_q, en_d;
  logic [2:0]        phase_q, phase_d;
  logic [1:0]        widx_q, widx_d;
  logic [PulseW-1:0] pulses_q, pulses_d;
  logic [9:0]        wait_q, wait_d;
  logic [3:0]        cur_code_q, cur_code_d;
  logic [CodeW-1:0]  timer_code_q;
  logic              strobe_q, strobe_d;

  logic              div_busy_q;
  logic              div_start;
  logic [19:0]       rem_q;
  logic [CodeW-1:0]  cnt_q;
  logic              div_go;

  logic out_valid_q;
  logic flen_out_q, en_out_q, busy_out_q, movie_out_q, drop_out_q;
  logic dropped;

  logic              in_acc;
  logic [9:0]        eff_latch, eff_off, eff_half, wait_dec;
  logic [PulseW-1:0] addr_cnt, data_cnt, ld_cnt, pulses_dec;
  logic              last_write, taken;
  logic [2:0]        next_step;
  logic [3:0]        lvl_sat;
  ucode_t            uw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !div_busy_q && (!out_valid_q || out_ready_i);
  assign in_acc = in_valid_i && in_ready_o;

  assign eff_latch = (latch_q == '0) ? 10'd1 : latch_q;
  assign eff_off = (off_delay_q == '0) ? 10'd1 : {2'b00, off_delay_q};
  assign eff_half = (half_pulse_q == '0) ? 10'd1 : {6'd0, half_pulse_q};

  always_comb begin
    if (strobe_q) begin
      addr_cnt = PulseW'(ADDR_TIMER);
      data_cnt = PulseW'(timer_code_q);
    end else begin
      case (widx_q)
        WIDX_RATIO: begin
          addr_cnt = PulseW'(ADDR_RATIO);
          data_cnt = PulseW'(RATIO_VALUE);
        end
        WIDX_CURRENT: begin
          addr_cnt = PulseW'(ADDR_CURRENT);
          data_cnt = PulseW'(cur_code_q);
        end
        default: begin
          addr_cnt = PulseW'(ADDR_CONFIG);
          data_cnt = PulseW'(CONFIG_ON);
        end
      endcase
    end
  end

  assign uw = ucode(phase_q);
  assign wait_dec = (wait_q == '0) ? '0 : wait_q - 10'd1;
  assign pulses_dec = (pulses_q == '0) ? '0 : pulses_q - PulseW'(1);
  assign ld_cnt = (uw.pulse_op == PULSE_LOAD_ADDR) ? addr_cnt : data_cnt;
  assign last_write = strobe_q || (widx_q == WIDX_CONFIG);

  always_comb begin
    case (uw.cond)
      COND_CNT_ZERO: taken = (ld_cnt == '0);
      COND_MORE:     taken = (pulses_dec != '0);
      COND_LAST:     taken = last_write;
      default:       taken = 1'b0;
    endcase
    next_step = taken ? uw.jump : uw.next;
  end

  assign lvl_sat = (level_i > BRIGHTNESS_LEVELS) ? BRIGHTNESS_LEVELS : level_i;

  always_comb begin
    movie_d = movie_q;
    flen_d = flen_q;
    en_d = en_q;
    phase_d = phase_q;
    widx_d = widx_q;
    pulses_d = pulses_q;
    wait_d = wait_q;
    cur_code_d = cur_code_q;
    strobe_d = strobe_q;
    dropped = 1'b0;
    div_start = 1'b0;
    if (in_acc) begin
      case (req_type_i)
        REQ_TICK: begin
          if (phase_q != STEP_IDLE) begin
            if (wait_dec != '0) begin
              wait_d = wait_dec;
            end else begin
              phase_d = next_step;
              case (uw.en_op)
                EN_CLR:  en_d = 1'b0;
                EN_SET:  en_d = 1'b1;
                default: en_d = en_q;
              endcase
              case (uw.pulse_op)
                PULSE_LOAD_ADDR, PULSE_LOAD_DATA: pulses_d = ld_cnt;
                PULSE_DEC:                        pulses_d = pulses_dec;
                default:                          pulses_d = pulses_q;
              endcase
              if (uw.finish) begin
                if (strobe_q) begin
                  flen_d = 1'b1;
                end else if (widx_q == WIDX_RATIO) begin
                  movie_d = 1'b1;
                end
                if (!last_write) begin
                  widx_d = widx_q + 2'd1;
                end
              end
              case (next_step)
                STEP_OFF: begin
                  flen_d = 1'b0;
                  en_d = 1'b0;
                  wait_d = eff_off;
                end
                STEP_A_LOW, STEP_A_HIGH, STEP_D_LOW, STEP_D_HIGH: wait_d = eff_half;
                STEP_A_LATCH, STEP_D_LATCH: wait_d = eff_latch;
                default: wait_d = '0;
              endcase
            end
          end
        end
        REQ_TORCH, REQ_STROBE: begin
          if (phase_q != STEP_IDLE) begin
            dropped = 1'b1;
          end else if (level_i == '0) begin
            flen_d = 1'b0;
            en_d = 1'b0;
            movie_d = 1'b0;
          end else begin
            flen_d = 1'b0;
            en_d = 1'b0;
            phase_d = STEP_OFF;
            wait_d = eff_off;
            if (req_type_i == REQ_TORCH) begin
              cur_code_d = 4'(CURRENT_BASE - {1'b0, lvl_sat});
              strobe_d = 1'b0;
              widx_d = movie_q ? WIDX_CURRENT : WIDX_RATIO;
            end else begin
              movie_d = 1'b0;
              strobe_d = 1'b1;
              widx_d = WIDX_RATIO;
              div_start = 1'b1;
            end
          end
        end
        default: begin
          dropped = 1'b0;
        end
      endcase
    end
  end

  assign div_go = ({4'd0, timeout_step_q} <= rem_q) && (cnt_q < TlCode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_timeout_q <= FLASH_TIMEOUT_RST;
      timeout_step_q <= TIMEOUT_STEP_RST;
      latch_q <= LATCH_RST;
      off_delay_q <= OFF_DELAY_RST;
      half_pulse_q <= HALF_PULSE_RST;
      movie_q <= 1'b0;
      flen_q <= 1'b0;
      en_q <= 1'b0;
      phase_q <= STEP_IDLE;
      widx_q <= WIDX_RATIO;
      pulses_q <= '0;
      wait_q <= '0;
      cur_code_q <= '0;
      timer_code_q <= '0;
      strobe_q <= 1'b0;
      div_busy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_FLASH_TIMEOUT: flash_timeout_q <= cfg_data_i;
          CFG_TIMEOUT_STEP:  timeout_step_q <= cfg_data_i[15:0];
          CFG_LATCH:         latch_q <= cfg_data_i[9:0];
          CFG_OFF_DELAY:     off_delay_q <= cfg_data_i[7:0];
          CFG_HALF_PULSE:    half_pulse_q <= cfg_data_i[3:0];
          default:           latch_q <= latch_q;
        endcase
      end
      movie_q <= movie_d;
      flen_q <= flen_d;
      en_q <= en_d;
      phase_q <= phase_d;
      widx_q <= widx_d;
      pulses_q <= pulses_d;
      wait_q <= wait_d;
      cur_code_q <= cur_code_d;
      strobe_q <= strobe_d;
      if (div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_busy_q && !div_go) begin
        div_busy_q <= 1'b0;
        timer_code_q <= (cnt_q == '0) ? TlCode : CodeW'(TlPlusOne - {1'b0, cnt_q});
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      rem_q <= flash_timeout_q;
      cnt_q <= '0;
    end else if (div_busy_q && div_go) begin
      rem_q <= rem_q - {4'd0, timeout_step_q};
      cnt_q <= cnt_q + CodeW'(1);
    end
    if (in_acc) begin
      flen_out_q <= flen_d;
      en_out_q <= en_d;
      busy_out_q <= (phase_d != STEP_IDLE);
      movie_out_q <= movie_d;
      drop_out_q <= dropped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign flen_pin_o = flen_out_q;
  assign en_set_pin_o = en_out_q;
  assign busy_res_o = busy_out_q;
  assign movie_mode_on_o = movie_out_q;
  assign cmd_dropped_o = drop_out_q;

  `PCFL_ASSERT_NOW(a_div_in_strobe, div_busy_q, strobe_q && (phase_q != STEP_IDLE),
                   "divider runs outside a strobe write")
  `PCFL_ASSERT_NOW(a_flen_idle, flen_q, phase_q == STEP_IDLE,
                   "flash enable high during a write")
  `PCFL_ASSERT_NOW(a_pulses_live,
                   (phase_q == STEP_A_LOW) || (phase_q == STEP_A_HIGH) ||
                   (phase_q == STEP_D_LOW) || (phase_q == STEP_D_HIGH),
                   pulses_q != '0, "pulse step with no pulses left")
  `PCFL_ASSERT_NEXT(a_drop_busy, in_acc && dropped,
                    out_valid_o && busy_res_o && cmd_dropped_o,
                    "dropped beat not reported as busy")

endmodule

@@ tb/tb_pulse_count_flash_led_controller.sv @@
module tb_pulse_count_flash_led_controller;
  import pcfl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [3:0] LEVEL_OFF = 4'd0;
  localparam logic [3:0] LEVEL_ON = 4'd1;
  localparam logic [3:0] LEVEL_FULL = 4'd15;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = TIMER_LEVELS_DEF + 4;
  localparam int RANDOM_PHASES = 3;
  localparam int PHASE_BEATS = 10;

  typedef struct packed {
    logic flen;
    logic en_set;
    logic busy;
    logic movie;
    logic dropped;
  } pin_state_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            req_type_i;
  logic [3:0]            level_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  flen_pin_o;
  logic                  en_set_pin_o;
  logic                  busy_res_o;
  logic                  movie_mode_on_o;
  logic                  cmd_dropped_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pulse_count_flash_led_controller DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .level_i        (level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .flen_pin_o     (flen_pin_o),
    .en_set_pin_o   (en_set_pin_o),
    .busy_res_o     (busy_res_o),
    .movie_mode_on_o(movie_mode_on_o),
    .cmd_dropped_o  (cmd_dropped_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [19:0] timeout_us = FLASH_TIMEOUT_RST;
  logic [15:0] step_us = TIMEOUT_STEP_RST;
  logic [9:0]  latch_len = LATCH_RST;
  logic [7:0]  off_len = OFF_DELAY_RST;
  logic [3:0]  half_len = HALF_PULSE_RST;

  logic       movie_on = 1'b0;
  logic       flen_lvl = 1'b0;
  logic       enset_lvl = 1'b0;
  logic [2:0] seq_step = STEP_IDLE;
  logic [1:0] write_sel = WIDX_RATIO;
  logic [4:0] pulse_cnt = '0;
  logic [9:0] delay_cnt = '0;
  logic [3:0] torch_code = '0;
  logic [4:0] safety_code = '0;
  logic       strobe_write = 1'b0;

  pin_state_t pin_state_q[$];
  int mismatch_count = 0;
  int beats_sent = 0;
  int in_gap_max = 15;
  int out_gap_max = 15;

  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  function automatic void begin_write();
    flen_lvl = 1'b0;
    enset_lvl = 1'b0;
    seq_step = STEP_OFF;
    delay_cnt = at_least_one({2'b0, off_len});
  endfunction

  function automatic void begin_burst(input logic [4:0] count, input logic [2:0] pulse_step,
                                      input logic [2:0] latch_step);
    if (count == '0) begin
      seq_step = latch_step;
      delay_cnt = at_least_one(latch_len);
    end else begin
      pulse_cnt = count;
      seq_step = pulse_step;
      delay_cnt = at_least_one({6'b0, half_len});
    end
  endfunction

  function automatic logic [4:0] safety_timer_code();
    logic [31:0] quot;
    logic [31:0] code;
    if (step_us == '0) return 5'd1;
    quot = timeout_us / step_us;
    if (quot >= TIMER_LEVELS_DEF) return 5'd1;
    code = (quot == 0) ? TIMER_LEVELS_DEF : TIMER_LEVELS_DEF + 1 - quot;
    return code[4:0];
  endfunction

  function automatic void advance_sequencer();
    if (seq_step == STEP_IDLE) return;
    if (delay_cnt != '0) delay_cnt = delay_cnt - 10'd1;
    if (delay_cnt != '0) return;
    case (seq_step)
      STEP_OFF: begin
        begin_burst(strobe_write ? ADDR_TIMER :
                    (write_sel == WIDX_RATIO) ? ADDR_RATIO :
                    (write_sel == WIDX_CURRENT) ? ADDR_CURRENT : ADDR_CONFIG,
                    STEP_A_LOW, STEP_A_LATCH);
      end
      STEP_A_LOW, STEP_D_LOW: begin
        enset_lvl = 1'b0;
        seq_step = seq_step + 3'd1;
        delay_cnt = at_least_one({6'b0, half_len});
      end
      STEP_A_HIGH, STEP_D_HIGH: begin
        enset_lvl = 1'b1;
        if (pulse_cnt != '0) pulse_cnt = pulse_cnt - 5'd1;
        if (pulse_cnt != '0) begin
          seq_step = seq_step - 3'd1;
          delay_cnt = at_least_one({6'b0, half_len});
        end else begin
          seq_step = seq_step + 3'd1;
          delay_cnt = at_least_one(latch_len);
        end
      end
      STEP_A_LATCH: begin
        begin_burst(strobe_write ? safety_code :
                    (write_sel == WIDX_RATIO) ? RATIO_VALUE :
                    (write_sel == WIDX_CURRENT) ? {1'b0, torch_code} : CONFIG_ON,
                    STEP_D_LOW, STEP_D_LATCH);
      end
      default: begin
        if (strobe_write) begin
          flen_lvl = 1'b1;
          seq_step = STEP_IDLE;
        end else begin
          if (write_sel == WIDX_RATIO) movie_on = 1'b1;
          if (write_sel != WIDX_CONFIG) begin
            write_sel = write_sel + 2'd1;
            begin_write();
          end else begin
            seq_step = STEP_IDLE;
          end
        end
      end
    endcase
  endfunction

  function automatic pin_state_t predict_pins(input logic [1:0] kind, input logic [3:0] lvl);
    pin_state_t r;
    logic [3:0] b;
    logic [4:0] diff;
    r.dropped = 1'b0;
    if (kind == REQ_TICK) begin
      advance_sequencer();
    end else if (kind == REQ_TORCH || kind == REQ_STROBE) begin
      if (seq_step != STEP_IDLE) begin
        r.dropped = 1'b1;
      end else if (lvl == LEVEL_OFF) begin
        flen_lvl = 1'b0;
        enset_lvl = 1'b0;
        movie_on = 1'b0;
      end else if (kind == REQ_TORCH) begin
        b = (lvl > BRIGHTNESS_LEVELS) ? BRIGHTNESS_LEVELS : lvl;
        diff = CURRENT_BASE - {1'b0, b};
        torch_code = diff[3:0];
        strobe_write = 1'b0;
        write_sel = movie_on ? WIDX_CURRENT : WIDX_RATIO;
        begin_write();
      end else begin
        movie_on = 1'b0;
        safety_code = safety_timer_code();
        strobe_write = 1'b1;
        write_sel = WIDX_RATIO;
        begin_write();
      end
    end
    r.flen = flen_lvl;
    r.en_set = enset_lvl;
    r.busy = (seq_step != STEP_IDLE);
    r.movie = movie_on;
    return r;
  endfunction

  function automatic int draw_gap(input int max_gap);
    if (max_gap == 0 || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic send_beat(input logic [1:0] kind, input logic [3:0] lvl);
    int gap;
    gap = draw_gap(in_gap_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    level_i <= lvl;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    pin_state_q.push_back(predict_pins(kind, lvl));
    beats_sent++;
  endtask

  task automatic send_tick();
    logic [3:0] lvl;
    lvl = 4'($urandom_range(0, 15));
    send_beat(REQ_TICK, lvl);
  endtask

  task automatic send_random_command();
    int pick;
    logic [3:0] lvl;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) lvl = LEVEL_OFF;
    else lvl = 4'($urandom_range(1, 15));
    if (pick < 4) send_beat(REQ_TORCH, lvl);
    else if (pick < 8) send_beat(REQ_STROBE, lvl);
    else send_beat(REQ_UNUSED, lvl);
  endtask

  task automatic tick_until_idle();
    while (seq_step != STEP_IDLE) send_tick();
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pin_state_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_FLASH_TIMEOUT: timeout_us = val;
      CFG_TIMEOUT_STEP:  step_us = val[15:0];
      CFG_LATCH:         latch_len = val[9:0];
      CFG_OFF_DELAY:     off_len = val[7:0];
      CFG_HALF_PULSE:    half_len = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic strobe_with_timeout(input logic [19:0] timeout, input logic [15:0] step);
    logic [3:0] lvl;
    lvl = 4'($urandom_range(1, 15));
    settle_block();
    write_reg(CFG_FLASH_TIMEOUT, timeout);
    write_reg(CFG_TIMEOUT_STEP, {4'b0, step});
    send_beat(REQ_STROBE, lvl);
    tick_until_idle();
  endtask

  task automatic test_idle_requests();
    send_beat(REQ_TICK, LEVEL_FULL);
    send_beat(REQ_UNUSED, LEVEL_FULL);
    send_beat(REQ_TORCH, LEVEL_OFF);
    send_beat(REQ_STROBE, LEVEL_OFF);
  endtask

  task automatic test_torch_sequence();
    settle_block();
    write_reg(CFG_LATCH, 20'd1);
    send_beat(REQ_TORCH, LEVEL_FULL);
    repeat (3) send_beat(REQ_TICK, LEVEL_OFF);
    send_beat(REQ_TORCH, 4'd7);
    send_beat(REQ_STROBE, LEVEL_ON);
    send_beat(REQ_UNUSED, LEVEL_OFF);
    tick_until_idle();
    send_beat(REQ_TORCH, LEVEL_ON);
    tick_until_idle();
  endtask

  task automatic test_strobe_sequence();
    send_beat(REQ_STROBE, 4'd8);
    tick_until_idle();
    send_beat(REQ_STROBE, LEVEL_OFF);
    send_beat(REQ_TORCH, LEVEL_OFF);
  endtask

  task automatic test_timer_codes();
    settle_block();
    write_reg(CFG_LATCH, '0);
    write_reg(CFG_OFF_DELAY, '0);
    write_reg(CFG_HALF_PULSE, '0);
    strobe_with_timeout(20'd1, 16'hFFFF);
    strobe_with_timeout(20'd5000, 16'd0);
    strobe_with_timeout(20'd15999, 16'd1000);
  endtask

  task automatic test_random_traffic();
    int phase_start;
    logic [31:0] step;
    logic [31:0] timeout;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      if ($urandom_range(0, 3) == 0) step = $urandom_range(1, 65535);
      else step = $urandom_range(1, 3000);
      timeout = step * $urandom_range(0, 20) + $urandom_range(0, step - 1);
      write_reg(CFG_FLASH_TIMEOUT, timeout[19:0]);
      write_reg(CFG_TIMEOUT_STEP, step[19:0]);
      if ($urandom_range(0, 4) == 0) write_reg(CFG_LATCH, 20'($urandom_range(0, 40)));
      else write_reg(CFG_LATCH, 20'($urandom_range(1, 6)));
      write_reg(CFG_OFF_DELAY, 20'($urandom_range(0, 5)));
      write_reg(CFG_HALF_PULSE, 20'($urandom_range(0, 2)));
      in_gap_max = (p % 3 == 1) ? 0 : 15;
      out_gap_max = (p % 3 == 2) ? 0 : 15;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) begin
        send_random_command();
        if ($urandom_range(0, 3) != 0) begin
          while (seq_step != STEP_IDLE) begin
            if ($urandom_range(0, 19) == 0) send_random_command();
            else send_tick();
          end
          repeat ($urandom_range(0, 4)) send_tick();
        end else begin
          repeat ($urandom_range(0, 20)) send_tick();
        end
      end
      tick_until_idle();
    end
  endtask

  // Stalls are counted only while a result beat is waiting.
  initial begin : result_check
    pin_state_t want;
    int hold;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    hold = draw_gap(out_gap_max);
    forever begin
      @(negedge clk_i);
      out_ready_i <= (hold == 0);
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (pin_state_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = pin_state_q.pop_front();
          if (flen_pin_o !== want.flen)
            report_mismatch($sformatf("flen_pin got %b expected %b", flen_pin_o, want.flen));
          if (en_set_pin_o !== want.en_set)
            report_mismatch($sformatf("en_set_pin got %b expected %b",
                                      en_set_pin_o, want.en_set));
          if (busy_res_o !== want.busy)
            report_mismatch($sformatf("busy_res got %b expected %b", busy_res_o, want.busy));
          if (movie_mode_on_o !== want.movie)
            report_mismatch($sformatf("movie_mode_on got %b expected %b",
                                      movie_mode_on_o, want.movie));
          if (cmd_dropped_o !== want.dropped)
            report_mismatch($sformatf("cmd_dropped got %b expected %b",
                                      cmd_dropped_o, want.dropped));
        end
        hold = draw_gap(out_gap_max);
      end else if (hold > 0 && out_valid_o === 1'b1) begin
        hold--;
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("pulse_count_flash_led_controller verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_TICK;
    level_i = LEVEL_OFF;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FLASH_TIMEOUT;
    cfg_data_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_requests();
    test_torch_sequence();
    test_strobe_sequence();
    test_timer_codes();
    test_random_traffic();
    settle_block();
    if (mismatch_count == 0) begin
      $display("pulse_count_flash_led_controller verification clean");
    end else begin
      $display("pulse_count_flash_led_controller verification failed");
    end
    $finish;
  end

endmodule
